FILE: rtl/mfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants of the marker frame deframer.
// ----------------------------------------------------------------------------
package mfd_pkg;

  // Packet layout, byte offsets within a packet
  localparam logic [31:0] POS_LEN_LAST    = 32'd3;
  localparam logic [31:0] POS_TYPE_LAST   = 32'd7;
  localparam logic [31:0] POS_FRAME_FIRST = 32'd20;
  localparam logic [31:0] POS_FRAME_LAST  = 32'd23;
  localparam logic [31:0] POS_STAMP_FIRST = 32'd24;
  localparam logic [31:0] POS_STAMP_LAST  = 32'd31;
  localparam logic [31:0] POS_EMPTY_CHECK = 32'd35;
  localparam logic [31:0] HDR_LEN         = 32'd8;
  localparam logic [31:0] DATA_HDR_LEN    = 32'd36;
  // low nibble of the position of the last byte of a record
  localparam logic [3:0]  REC_LAST_NIBBLE = 4'd3;

  // Packet types
  localparam logic [31:0] TYPE_DATA  = 32'd3;
  localparam logic [31:0] TYPE_ERROR = 32'd4;

  // Result kinds
  localparam logic [1:0] KIND_MARKER    = 2'd0;
  localparam logic [1:0] KIND_ERROR     = 2'd1;
  localparam logic [1:0] KIND_MALFORMED = 2'd2;
  localparam logic [1:0] KIND_EMPTY     = 2'd3;

  localparam int unsigned IDX_W = 28;

  // Operations handed from the parser to the result builder
  typedef enum logic [2:0] {
    OP_FRAME,
    OP_STAMP,
    OP_REC,
    OP_REC_END,
    OP_ERROR,
    OP_MALFORMED,
    OP_EMPTY
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic             last;
  } tok_t;

endpackage

FILE: rtl/mfd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_in_if
// Byte stream channel into the deframer.
// ----------------------------------------------------------------------------
interface mfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

FILE: rtl/mfd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_out_if
// Result channel out of the deframer.
// ----------------------------------------------------------------------------
interface mfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] frame_id;
  logic [63:0] frame_stamp;
  logic [27:0] marker_index;
  logic [31:0] x_bits;
  logic [31:0] y_bits;
  logic [31:0] z_bits;
  logic [31:0] reliability_bits;
  logic        in_view;
  logic        last_marker;

  modport source (
    output valid, output kind, output frame_id, output frame_stamp,
    output marker_index, output x_bits, output y_bits, output z_bits,
    output reliability_bits, output in_view, output last_marker,
    input ready
  );
  modport sink (
    input valid, input kind, input frame_id, input frame_stamp,
    input marker_index, input x_bits, input y_bits, input z_bits,
    input reliability_bits, input in_view, input last_marker,
    output ready
  );
endinterface

FILE: rtl/marker_frame_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marker_frame_deframer_top
// Splits a byte stream into packets and reports marker records and errors.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while the queue has room and gives at most
// one result per byte. A parser tracks the byte position and header of each
// packet and tags the bytes that matter; a short queue carries the tagged
// words to a result builder that assembles frame number, timestamp and
// 16-byte marker records into a registered output. The word of the byte that
// completes a result passes through the queue and is then loaded into the
// result register. The input keeps flowing while a result waits on the output
// until the queue (FifoDepth words) fills; bytes that carry nothing the builder
// needs take no queue space. No clearing pass follows reset.
module marker_frame_deframer_top #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mfd_in_if.sink     in_i,
  mfd_out_if.source  out_o
);

  logic          push, full, pop, head_valid;
  mfd_pkg::tok_t push_tok, head_tok;

  mfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .fifo_full_i (full),
    .push_o      (push),
    .tok_o       (push_tok)
  );

  mfd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (push_tok),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .tok_o   (head_tok)
  );

  mfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .tok_i        (head_tok),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

FILE: rtl/mfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_front
// Packet parser: tracks the byte position, decodes the header and tags the
// bytes that matter with an operation for the result builder.
// ----------------------------------------------------------------------------
module mfd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  mfd_in_if.sink        in_i,
  input  logic          fifo_full_i,
  output logic          push_o,
  output mfd_pkg::tok_t tok_o
);

  logic                           accept;
  logic [31:0]                    pos_q, pos_d;
  logic [31:0]                    len_q, len_d;
  logic [31:0]                    shift_q, shift_d;
  logic                           data_q, data_d;
  logic [mfd_pkg::IDX_W-1:0]      rc_q, rc_d;
  logic [mfd_pkg::IDX_W-1:0]      rn_q, rn_d;
  logic [mfd_pkg::IDX_W-1:0]      rn_inc;
  logic [31:0]                    body_len;

  assign in_i.ready = !fifo_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign rn_inc     = rn_q + mfd_pkg::IDX_W'(1);
  assign body_len   = len_q - mfd_pkg::DATA_HDR_LEN;

  // Decode position and header, build the operation for this word
  always_comb begin
    pos_d   = pos_q;
    len_d   = len_q;
    shift_d = shift_q;
    data_d  = data_q;
    rc_d    = rc_q;
    rn_d    = rn_q;
    push_o  = 1'b0;
    tok_o   = '0;
    tok_o.data = in_i.data_byte;
    if (accept) begin
      shift_d = {shift_q[23:0], in_i.data_byte};
      if (pos_q == mfd_pkg::POS_LEN_LAST) begin
        len_d = shift_d;
      end
      // advance, or restart at the end of the packet
      if (pos_q >= mfd_pkg::POS_TYPE_LAST && pos_q + 32'd1 == len_q) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + 32'd1;
      end
      if (pos_q == mfd_pkg::POS_TYPE_LAST) begin
        rn_d   = '0;
        rc_d   = '0;
        data_d = 1'b0;
        priority if (len_q < mfd_pkg::HDR_LEN) begin
          push_o   = 1'b1;
          tok_o.op = mfd_pkg::OP_MALFORMED;
          pos_d    = '0;
        end else if (shift_d == mfd_pkg::TYPE_DATA) begin
          if (len_q < mfd_pkg::DATA_HDR_LEN) begin
            push_o   = 1'b1;
            tok_o.op = mfd_pkg::OP_MALFORMED;
          end else begin
            data_d = 1'b1;
            rc_d   = body_len[31:4];
          end
        end else if (shift_d == mfd_pkg::TYPE_ERROR) begin
          push_o   = 1'b1;
          tok_o.op = mfd_pkg::OP_ERROR;
        end else begin
          data_d = 1'b0;
        end
      end else if (data_q && pos_q > mfd_pkg::POS_TYPE_LAST) begin
        // tag data packet bytes
        priority if (pos_q >= mfd_pkg::POS_FRAME_FIRST &&
                     pos_q <= mfd_pkg::POS_FRAME_LAST) begin
          push_o   = 1'b1;
          tok_o.op = mfd_pkg::OP_FRAME;
        end else if (pos_q >= mfd_pkg::POS_STAMP_FIRST &&
                     pos_q <= mfd_pkg::POS_STAMP_LAST) begin
          push_o   = 1'b1;
          tok_o.op = mfd_pkg::OP_STAMP;
        end else if (pos_q == mfd_pkg::POS_EMPTY_CHECK && rc_q == '0) begin
          push_o   = 1'b1;
          tok_o.op = mfd_pkg::OP_EMPTY;
        end else if (pos_q >= mfd_pkg::DATA_HDR_LEN && rn_q < rc_q) begin
          push_o = 1'b1;
          if (pos_q[3:0] == mfd_pkg::REC_LAST_NIBBLE) begin
            tok_o.op   = mfd_pkg::OP_REC_END;
            tok_o.idx  = rn_q;
            tok_o.last = (rn_inc == rc_q);
            rn_d       = rn_inc;
          end else begin
            tok_o.op = mfd_pkg::OP_REC;
          end
        end else begin
          push_o = 1'b0;
        end
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      len_q   <= '0;
      shift_q <= '0;
      data_q  <= 1'b0;
      rc_q    <= '0;
      rn_q    <= '0;
    end else begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      shift_q <= shift_d;
      data_q  <= data_d;
      rc_q    <= rc_d;
      rn_q    <= rn_d;
    end
  end

endmodule

FILE: rtl/mfd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_fifo
// Short operation queue between the parser and the result builder.
// ----------------------------------------------------------------------------
module mfd_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mfd_pkg::tok_t tok_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mfd_pkg::tok_t tok_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  mfd_pkg::tok_t   mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign tok_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= tok_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_pop_changes_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("pop did not lower the fill count");

endmodule

FILE: rtl/mfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_back
// Result builder: assembles frame number, timestamp and marker records from
// tagged words and drives the registered result channel.
// ----------------------------------------------------------------------------
module mfd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  mfd_pkg::tok_t tok_i,
  output logic          pop_o,
  mfd_out_if.source     out_o
);

  logic [31:0]  frame_q;
  logic [63:0]  stamp_q;
  logic [127:0] rec_q, rec_d;
  logic         emits, out_free;
  logic         out_valid_q;
  logic [1:0]   kind_q;
  logic [31:0]  frame_out_q;
  logic [63:0]  stamp_out_q;
  logic [27:0]  idx_q;
  logic [31:0]  x_q, y_q, z_q, rel_q;
  logic         in_view_q, last_q;

  assign rec_d    = {rec_q[119:0], tok_i.data};
  assign out_free = !out_valid_q || out_o.ready;

  // Classify operations that produce a result
  always_comb begin
    unique case (tok_i.op)
      mfd_pkg::OP_REC_END, mfd_pkg::OP_ERROR,
      mfd_pkg::OP_MALFORMED, mfd_pkg::OP_EMPTY: emits = 1'b1;
      default:                                   emits = 1'b0;
    endcase
  end

  assign pop_o = head_valid_i && (!emits || out_free);

  // Shift in frame, timestamp and record words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      stamp_q <= '0;
      rec_q   <= '0;
    end else if (pop_o) begin
      unique case (tok_i.op)
        mfd_pkg::OP_FRAME:               frame_q <= {frame_q[23:0], tok_i.data};
        mfd_pkg::OP_STAMP:               stamp_q <= {stamp_q[55:0], tok_i.data};
        mfd_pkg::OP_REC, mfd_pkg::OP_REC_END: rec_q <= rec_d;
        default:                         rec_q   <= rec_q;
      endcase
    end
  end

  // Load the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && emits) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emits) begin
      frame_out_q <= '0;
      stamp_out_q <= '0;
      idx_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      rel_q       <= '0;
      in_view_q   <= 1'b0;
      last_q      <= 1'b0;
      unique case (tok_i.op)
        mfd_pkg::OP_REC_END: begin
          kind_q      <= mfd_pkg::KIND_MARKER;
          frame_out_q <= frame_q;
          stamp_out_q <= stamp_q;
          idx_q       <= tok_i.idx;
          x_q         <= rec_d[127:96];
          y_q         <= rec_d[95:64];
          z_q         <= rec_d[63:32];
          rel_q       <= rec_d[31:0];
          in_view_q   <= (rec_d[63:32] != '1);
          last_q      <= tok_i.last;
        end
        mfd_pkg::OP_EMPTY: begin
          kind_q      <= mfd_pkg::KIND_EMPTY;
          frame_out_q <= frame_q;
          stamp_out_q <= stamp_q;
        end
        mfd_pkg::OP_ERROR: kind_q <= mfd_pkg::KIND_ERROR;
        default:           kind_q <= mfd_pkg::KIND_MALFORMED;
      endcase
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.kind             = kind_q;
  assign out_o.frame_id         = frame_out_q;
  assign out_o.frame_stamp      = stamp_out_q;
  assign out_o.marker_index     = idx_q;
  assign out_o.x_bits           = x_q;
  assign out_o.y_bits           = y_q;
  assign out_o.z_bits           = z_q;
  assign out_o.reliability_bits = rel_q;
  assign out_o.in_view          = in_view_q;
  assign out_o.last_marker      = last_q;

  a_rec_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && tok_i.op == mfd_pkg::OP_REC_END)
      |=> out_valid_q && kind_q == mfd_pkg::KIND_MARKER)
    else $error("record end did not produce a marker result");

  a_non_marker_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q != mfd_pkg::KIND_MARKER)
      |-> (idx_q == '0 && x_q == '0 && z_q == '0 && !in_view_q && !last_q))
    else $error("non-marker result carries marker fields");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the marker frame deframer.
// ----------------------------------------------------------------------------
// Feeds the deframer a byte stream built from packets. A short directed set
// covers tiny sizes, header-only packets, short data packets, error packets,
// empty frames, trailing bytes and all-zero / all-one field values. After
// that come mostly well-formed data packets with random content, mixed with
// error, unknown and broken packets. A scoreboard class tracks the packet
// parser state for every accepted byte and checks each result word in order.
// Both channels idle at random, and the receiver holds off long enough to
// fill the block and stall its input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned TARGET_ITEMS = 1300;
  localparam int unsigned MAX_PRINTS   = 50;

  // Byte offsets within a packet
  localparam logic [31:0] LEN_END     = 32'd3;
  localparam logic [31:0] TYPE_END    = 32'd7;
  localparam logic [31:0] FRAME_END   = 32'd23;
  localparam logic [31:0] STAMP_FIRST = 32'd24;
  localparam logic [31:0] STAMP_END   = 32'd31;
  localparam logic [31:0] EMPTY_AT    = 32'd35;
  localparam logic [31:0] REC_BYTES   = 32'd16;

  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  typedef struct packed {
    logic [1:0]                kind;
    logic [31:0]               frame_id;
    logic [63:0]               frame_stamp;
    logic [mfd_pkg::IDX_W-1:0] marker_index;
    logic [31:0]               x_bits;
    logic [31:0]               y_bits;
    logic [31:0]               z_bits;
    logic [31:0]               reliability_bits;
    logic                      in_view;
    logic                      last_marker;
  } marker_result_t;

  // Tracks the packet parser and holds the results still to come
  class marker_scoreboard;
    marker_result_t            pending_results[$];
    int unsigned               errors;
    int unsigned               results_seen;
    logic [31:0]               byte_pos;
    logic [31:0]               pkt_size;
    logic [31:0]               pkt_type;
    logic [31:0]               last_four;
    logic [31:0]               frame_no;
    logic [63:0]               stamp;
    logic [31:0]               coord[3];
    logic [mfd_pkg::IDX_W-1:0] rec_total;
    logic [mfd_pkg::IDX_W-1:0] rec_done;

    function new();
      errors       = 0;
      results_seen = 0;
      byte_pos     = '0;
      pkt_size     = '0;
      pkt_type     = '0;
      last_four    = '0;
      frame_no     = '0;
      stamp        = '0;
      coord[0]     = '0;
      coord[1]     = '0;
      coord[2]     = '0;
      rec_total    = '0;
      rec_done     = '0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    task report_mismatch(input string msg);
      if (errors < MAX_PRINTS) begin
        $display("%0t ns: ERROR %s", $time, msg);
      end
      errors++;
    endtask

    // Advance the parser by one accepted byte
    function void predict_byte(input logic [7:0] b);
      logic [31:0]    pos;
      logic [31:0]    off;
      marker_result_t res;
      bit             emit;
      bit             frame_ok;
      pos  = byte_pos;
      res  = '0;
      emit = 1'b0;
      last_four = {last_four[23:0], b};
      if (pos == LEN_END) begin
        pkt_size = last_four;
      end
      // Decode the header at its last byte
      if (pos == TYPE_END) begin
        pkt_type  = last_four;
        rec_done  = '0;
        rec_total = '0;
        if (pkt_size < mfd_pkg::HDR_LEN) begin
          res.kind = mfd_pkg::KIND_MALFORMED;
          pending_results.push_back(res);
          byte_pos = '0;
          return;
        end
        if (pkt_type == mfd_pkg::TYPE_DATA) begin
          if (pkt_size < mfd_pkg::DATA_HDR_LEN) begin
            res.kind = mfd_pkg::KIND_MALFORMED;
            emit     = 1'b1;
          end else begin
            rec_total = mfd_pkg::IDX_W'((pkt_size - mfd_pkg::DATA_HDR_LEN) / REC_BYTES);
          end
        end else if (pkt_type == mfd_pkg::TYPE_ERROR) begin
          res.kind = mfd_pkg::KIND_ERROR;
          emit     = 1'b1;
        end
      end
      frame_ok = (pos >= TYPE_END) && (pkt_type == mfd_pkg::TYPE_DATA) &&
                 (pkt_size >= mfd_pkg::DATA_HDR_LEN);
      // Collect frame fields and marker records of a valid data packet
      if (frame_ok && pos > TYPE_END) begin
        if (pos == FRAME_END) begin
          frame_no = last_four;
        end
        if (pos >= STAMP_FIRST && pos <= STAMP_END) begin
          stamp = {stamp[55:0], b};
        end
        if (pos == EMPTY_AT && rec_total == '0) begin
          res.kind        = mfd_pkg::KIND_EMPTY;
          res.frame_id    = frame_no;
          res.frame_stamp = stamp;
          emit            = 1'b1;
        end
        if (pos >= mfd_pkg::DATA_HDR_LEN && rec_done < rec_total) begin
          off = (pos - mfd_pkg::DATA_HDR_LEN) % REC_BYTES;
          if (off[1:0] == 2'd3) begin
            if (off[3:2] != 2'd3) begin
              coord[off[3:2]] = last_four;
            end else begin
              res.kind             = mfd_pkg::KIND_MARKER;
              res.frame_id         = frame_no;
              res.frame_stamp      = stamp;
              res.marker_index     = rec_done;
              res.x_bits           = coord[0];
              res.y_bits           = coord[1];
              res.z_bits           = coord[2];
              res.reliability_bits = last_four;
              res.in_view          = (coord[2] != 32'hFFFF_FFFF);
              res.last_marker      = (rec_done + 1'b1 == rec_total);
              rec_done             = rec_done + 1'b1;
              emit                 = 1'b1;
            end
          end
        end
      end
      if (emit) begin
        pending_results.push_back(res);
      end
      // Wrap to the next packet at its last byte
      if (pos >= TYPE_END && pos + 32'd1 == pkt_size) begin
        byte_pos = '0;
      end else begin
        byte_pos = pos + 32'd1;
      end
    endfunction

    // Compare one delivered result with the oldest expectation
    task check_result(input marker_result_t got);
      marker_result_t exp;
      int unsigned    n;
      n = results_seen;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected (kind %0d)",
                                  n, got.kind));
        return;
      end
      exp = pending_results.pop_front();
      if (got.kind !== exp.kind)
        report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                  n, got.kind, exp.kind));
      if (got.frame_id !== exp.frame_id)
        report_mismatch($sformatf("result %0d frame_id %h, expected %h",
                                  n, got.frame_id, exp.frame_id));
      if (got.frame_stamp !== exp.frame_stamp)
        report_mismatch($sformatf("result %0d frame_stamp %h, expected %h",
                                  n, got.frame_stamp, exp.frame_stamp));
      if (got.marker_index !== exp.marker_index)
        report_mismatch($sformatf("result %0d marker_index %0d, expected %0d",
                                  n, got.marker_index, exp.marker_index));
      if (got.x_bits !== exp.x_bits)
        report_mismatch($sformatf("result %0d x_bits %h, expected %h",
                                  n, got.x_bits, exp.x_bits));
      if (got.y_bits !== exp.y_bits)
        report_mismatch($sformatf("result %0d y_bits %h, expected %h",
                                  n, got.y_bits, exp.y_bits));
      if (got.z_bits !== exp.z_bits)
        report_mismatch($sformatf("result %0d z_bits %h, expected %h",
                                  n, got.z_bits, exp.z_bits));
      if (got.reliability_bits !== exp.reliability_bits)
        report_mismatch($sformatf("result %0d reliability_bits %h, expected %h",
                                  n, got.reliability_bits, exp.reliability_bits));
      if (got.in_view !== exp.in_view)
        report_mismatch($sformatf("result %0d in_view %b, expected %b",
                                  n, got.in_view, exp.in_view));
      if (got.last_marker !== exp.last_marker)
        report_mismatch($sformatf("result %0d last_marker %b, expected %b",
                                  n, got.last_marker, exp.last_marker));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  marker_scoreboard sb = new();
  int unsigned      cycle_count = 0;
  int unsigned      bytes_accepted = 0;
  bit               send_calm = 1'b0;
  logic             hold_off = 1'b0;

  mfd_in_if  in_if ();
  mfd_out_if out_if ();

  marker_frame_deframer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending());
      $display("marker_frame_deframer_top verification failed");
      $finish;
    end
  end

  // Idle cycles before the next word, mostly short, a few long
  function automatic int unsigned sender_gap();
    int unsigned r;
    if (send_calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Field word, biased toward all zeros and all ones; z words often off view
  function automatic logic [31:0] pick_word(input fill_e fill, input bit z_word);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (fill)
      FILL_ZERO: return 32'h0000_0000;
      FILL_ONES: return 32'hFFFF_FFFF;
      default: begin
        if (z_word && r < 25) return 32'hFFFF_FFFF;
        if (r < 35) return 32'h0000_0000;
        if (r < 45) return 32'hFFFF_FFFF;
        return $urandom();
      end
    endcase
  endfunction

  // Offer one word and hold it until taken
  task automatic send_stream_byte(input logic [7:0] b);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.predict_byte(b);
    bytes_accepted++;
  endtask

  // Send a whole packet; sizes below the header still take eight bytes
  task automatic send_packet(input logic [31:0] size_word, input logic [31:0] type_word,
                             input fill_e fill);
    logic [31:0] total;
    logic [31:0] frame_word;
    logic [63:0] stamp_word;
    logic [31:0] rec_word;
    logic [7:0]  b;
    bit          frame_ok;
    int          p;
    int          rp;
    total      = (size_word < mfd_pkg::HDR_LEN) ? mfd_pkg::HDR_LEN : size_word;
    frame_ok   = (type_word == mfd_pkg::TYPE_DATA) && (size_word >= mfd_pkg::DATA_HDR_LEN);
    frame_word = pick_word(fill, 1'b0);
    stamp_word = {pick_word(fill, 1'b0), pick_word(fill, 1'b0)};
    rec_word   = '0;
    send_calm  = ($urandom_range(0, 4) == 0);
    for (p = 0; p < int'(total); p++) begin
      rp = p - 36;
      if (p < 4) begin
        b = size_word[8*(3-p) +: 8];
      end else if (p < 8) begin
        b = type_word[8*(7-p) +: 8];
      end else if (frame_ok && p >= 20 && p <= 23) begin
        b = frame_word[8*(23-p) +: 8];
      end else if (frame_ok && p >= 24 && p <= 31) begin
        b = stamp_word[8*(31-p) +: 8];
      end else if (frame_ok && p >= 36) begin
        if (rp % 4 == 0) begin
          rec_word = pick_word(fill, (rp / 4) % 4 == 2);
        end
        b = rec_word[8*(3-(rp%4)) +: 8];
      end else begin
        case (fill)
          FILL_ZERO: b = 8'h00;
          FILL_ONES: b = 8'hFF;
          default:   b = 8'($urandom_range(0, 255));
        endcase
      end
      send_stream_byte(b);
    end
  endtask

  function automatic logic [31:0] pick_type();
    case ($urandom_range(0, 2))
      0:       return mfd_pkg::TYPE_DATA;
      1:       return mfd_pkg::TYPE_ERROR;
      default: return $urandom();
    endcase
  endfunction

  // Result side: check taken words, then choose ready for the next cycle
  initial begin
    int unsigned    stall_left;
    int unsigned    calm_left;
    int unsigned    r;
    marker_result_t got;
    stall_left = 0;
    calm_left  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.kind             = out_if.kind;
        got.frame_id         = out_if.frame_id;
        got.frame_stamp      = out_if.frame_stamp;
        got.marker_index     = out_if.marker_index;
        got.x_bits           = out_if.x_bits;
        got.y_bits           = out_if.y_bits;
        got.z_bits           = out_if.z_bits;
        got.reliability_bits = out_if.reliability_bits;
        got.in_view          = out_if.in_view;
        got.last_marker      = out_if.last_marker;
        sb.check_result(got);
      end
      if (hold_off) begin
        out_if.ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          calm_left = $urandom_range(50, 200);
          out_if.ready <= 1'b1;
        end else if (r < 72) begin
          out_if.ready <= 1'b1;
        end else if (r < 95) begin
          stall_left = $urandom_range(0, 2);
          out_if.ready <= 1'b0;
        end else begin
          stall_left = $urandom_range(10, 50);
          out_if.ready <= 1'b0;
        end
      end
    end
  end

  // Hold the receiver off while bytes keep coming, so the block backs up
  initial begin
    wait (bytes_accepted >= 700);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
    wait (bytes_accepted >= 1100);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Reset, directed packets, random packets, drain
  initial begin
    int unsigned pick;
    int unsigned recs;
    int unsigned trail;
    logic [31:0] size_word;
    logic [31:0] type_word;
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sizes below the header, header-only, short data, error packets
    send_packet(32'd0, mfd_pkg::TYPE_DATA, FILL_RANDOM);
    send_packet(32'd7, mfd_pkg::TYPE_ERROR, FILL_ZERO);
    send_packet(32'd8, 32'd1, FILL_RANDOM);
    send_packet(32'd8, mfd_pkg::TYPE_DATA, FILL_RANDOM);
    send_packet(32'd35, mfd_pkg::TYPE_DATA, FILL_ONES);
    send_packet(32'd8, mfd_pkg::TYPE_ERROR, FILL_RANDOM);
    send_packet(32'd21, mfd_pkg::TYPE_ERROR, FILL_ONES);
    // Empty frames, with and without trailing bytes
    send_packet(32'd36, mfd_pkg::TYPE_DATA, FILL_ONES);
    send_packet(32'd51, mfd_pkg::TYPE_DATA, FILL_ZERO);
    // Marker records: all zeros in view, all ones off view, random
    send_packet(32'd52, mfd_pkg::TYPE_DATA, FILL_ZERO);
    send_packet(32'd83, mfd_pkg::TYPE_DATA, FILL_ONES);
    send_packet(32'd84, mfd_pkg::TYPE_DATA, FILL_RANDOM);
    // Unknown types skipped by size, one near the data type
    send_packet(32'd24, 32'hFFFF_FFFF, FILL_RANDOM);
    send_packet(32'd40, 32'h0100_0003, FILL_RANDOM);
    // Long frame, size above one byte
    send_packet(32'd260, mfd_pkg::TYPE_DATA, FILL_RANDOM);

    // Mostly well-formed frames, the rest error, unknown and broken packets
    while (bytes_accepted < TARGET_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        recs  = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 6);
        trail = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 15) : 0;
        size_word = 36 + 16 * recs + trail;
        send_packet(size_word, mfd_pkg::TYPE_DATA, FILL_RANDOM);
      end else begin
        if (pick < 73) begin
          size_word = $urandom_range(8, 40);
          type_word = mfd_pkg::TYPE_ERROR;
        end else if (pick < 81) begin
          size_word = $urandom_range(8, 60);
          type_word = $urandom();
          if (type_word == mfd_pkg::TYPE_DATA || type_word == mfd_pkg::TYPE_ERROR) begin
            type_word[31] = 1'b1;
          end
        end else if (pick < 89) begin
          size_word = $urandom_range(0, 7);
          type_word = pick_type();
        end else if (pick < 96) begin
          size_word = $urandom_range(8, 35);
          type_word = mfd_pkg::TYPE_DATA;
        end else begin
          size_word = mfd_pkg::HDR_LEN;
          type_word = pick_type();
        end
        send_packet(size_word, type_word, FILL_RANDOM);
      end
    end
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("marker_frame_deframer_top verification clean");
    end else begin
      $display("marker_frame_deframer_top verification failed");
    end
    $finish;
  end

endmodule
